[design/rgbcmyk_pkg.sv]
// ----------------------------------------------------------------------------
// rgbcmyk_pkg
// Shared widths, scale constants and constant lookup tables for the RGB to
// CMYK pixel converter.
// ----------------------------------------------------------------------------
package rgbcmyk_pkg;

  localparam int CHAN_W    = 8;
  localparam int PCT_W     = 14;
  localparam int FRAC_W    = 17;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 80;

  localparam int PCT_SCALE  = 10000;
  localparam int FRAC_SCALE = 65536;
  localparam int CHAN_FULL  = 255;

  // Numerator of the rounded quotient: 2*10000*diff + mx.
  localparam int NUM_W   = 23;
  // Reciprocal of 2*mx with 32 fractional bits.
  localparam int RECIP_W = 32;
  localparam int RECIP_SHIFT = 32;
  localparam int DEN_W   = 9;

  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [PCT_W-1:0]   pct_t;
  typedef logic [FRAC_W-1:0]  frac_t;
  typedef logic [NUM_W-1:0]   num_t;
  typedef logic [RECIP_W-1:0] recip_t;

  typedef pct_t   pct_lut_t   [256];
  typedef frac_t  frac_lut_t  [256];
  typedef recip_t recip_lut_t [256];

  function automatic pct_lut_t build_key_pct();
    pct_lut_t lut;
    int dark;
    for (int i = 0; i < 256; i++) begin
      dark   = CHAN_FULL - i;
      lut[i] = PCT_W'((2 * dark * PCT_SCALE + CHAN_FULL) / (2 * CHAN_FULL));
    end
    return lut;
  endfunction

  function automatic frac_lut_t build_key_frac();
    frac_lut_t lut;
    int dark;
    for (int i = 0; i < 256; i++) begin
      dark   = CHAN_FULL - i;
      lut[i] = FRAC_W'((2 * dark * FRAC_SCALE + CHAN_FULL) / (2 * CHAN_FULL));
    end
    return lut;
  endfunction

  // floor(2^32 / (2*mx)), formed by shift-and-subtract long division of 2^31
  // by mx; the entry for mx of zero is unused and held at zero.
  function automatic recip_lut_t build_recip();
    recip_lut_t         lut;
    logic [RECIP_W:0]   rem;
    logic [RECIP_W-1:0] quo;
    logic [RECIP_W-1:0] dividend;
    dividend = {1'b1, {(RECIP_W-1){1'b0}}};
    lut[0] = '0;
    for (int i = 1; i < 256; i++) begin
      rem = '0;
      quo = '0;
      for (int b = RECIP_W - 1; b >= 0; b--) begin
        rem = {rem[RECIP_W-1:0], dividend[b]};
        if (rem >= (RECIP_W + 1)'(i)) begin
          rem    = rem - (RECIP_W + 1)'(i);
          quo[b] = 1'b1;
        end
      end
      lut[i] = quo;
    end
    return lut;
  endfunction

  localparam pct_lut_t   KEY_PCT_LUT  = build_key_pct();
  localparam frac_lut_t  KEY_FRAC_LUT = build_key_frac();
  localparam recip_lut_t RECIP_LUT    = build_recip();

endpackage

[design/rgb_to_cmyk_pixel_top.sv]
// ----------------------------------------------------------------------------
// rgb_to_cmyk_pixel_top
// Four-stage pipelined RGB to CMYK converter with stream interfaces.
// ----------------------------------------------------------------------------
// Throughput: one pixel per clock while the master side is not stalled, set by
// the fully pipelined reciprocal multiply and correction stages.
// Reset: rst is synchronous and active high; it clears the stage valid bits
// only, so no result is presented after reset until new pixels arrive.
module rgb_to_cmyk_pixel_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // s_tdata fields from bit 0 up: red[7:0], green[15:8], blue[23:16]
  input  logic [rgbcmyk_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // m_tdata fields from bit 0 up: cyan_pct[13:0], magenta_pct[27:14],
  // yellow_pct[41:28], key_pct[55:42], key_fraction[72:56], zero[79:73]
  output logic [rgbcmyk_pkg::OUT_DATA_W-1:0] m_tdata
);
  import rgbcmyk_pkg::*;

  // The whole pipeline moves together. It advances whenever the output
  // register is empty or its transaction is being taken, so a new pixel can
  // enter in the same cycle a finished result leaves.
  logic ce;
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  // Stage valid bits.
  logic v1, v2, v3, v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (ce) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Stage 1: find the brightest channel, the distance of each channel from
  // it, and look up both key forms, which depend on the maximum alone.
  chan_t in_chan [3];
  assign in_chan[0] = s_tdata[7:0];
  assign in_chan[1] = s_tdata[15:8];
  assign in_chan[2] = s_tdata[23:16];

  chan_t mx_next;
  always_comb begin
    mx_next = in_chan[0];
    if (in_chan[1] > mx_next) mx_next = in_chan[1];
    if (in_chan[2] > mx_next) mx_next = in_chan[2];
  end

  chan_t mx1;
  chan_t diff1 [3];
  pct_t  kpct1;
  frac_t kfrac1;

  always_ff @(posedge clk) begin
    if (ce) begin
      mx1    <= mx_next;
      kpct1  <= KEY_PCT_LUT[mx_next];
      kfrac1 <= KEY_FRAC_LUT[mx_next];
      for (int c = 0; c < 3; c++) begin
        diff1[c] <= mx_next - in_chan[c];
      end
    end
  end

  // Stage 2: form the rounding numerator 2*10000*diff + mx for each ink and
  // fetch the reciprocal of the denominator 2*mx.
  chan_t  mx2;
  num_t   num2 [3];
  recip_t recip2;
  pct_t   kpct2;
  frac_t  kfrac2;

  always_ff @(posedge clk) begin
    if (ce) begin
      mx2    <= mx1;
      recip2 <= RECIP_LUT[mx1];
      kpct2  <= kpct1;
      kfrac2 <= kfrac1;
      for (int c = 0; c < 3; c++) begin
        num2[c] <= NUM_W'(diff1[c]) * NUM_W'(2 * PCT_SCALE) + NUM_W'(mx1);
      end
    end
  end

  // Stage 3: the reciprocal is rounded down, so the product gives a quotient
  // estimate that is exact or one below the true quotient.
  localparam int PROD_W = NUM_W + RECIP_W;

  logic [PROD_W-1:0] prod3 [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod3[c] = PROD_W'(num2[c]) * PROD_W'(recip2);
    end
  end

  chan_t mx3;
  num_t  num3 [3];
  pct_t  qest3 [3];
  pct_t  kpct3;
  frac_t kfrac3;

  always_ff @(posedge clk) begin
    if (ce) begin
      mx3    <= mx2;
      kpct3  <= kpct2;
      kfrac3 <= kfrac2;
      for (int c = 0; c < 3; c++) begin
        num3[c]  <= num2[c];
        qest3[c] <= prod3[c][RECIP_SHIFT +: PCT_W];
      end
    end
  end

  // Stage 4: check the remainder against the denominator and step the
  // estimate up by one where it fell short. A black pixel gives no ink.
  logic [DEN_W-1:0] den4;
  assign den4 = {mx3, 1'b0};

  pct_t ink_next [3];
  num_t rem4 [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rem4[c] = num3[c] - NUM_W'(qest3[c]) * NUM_W'(den4);
      if (mx3 == '0) begin
        ink_next[c] = '0;
      end else if (rem4[c] >= NUM_W'(den4)) begin
        ink_next[c] = qest3[c] + PCT_W'(1);
      end else begin
        ink_next[c] = qest3[c];
      end
    end
  end

  pct_t  ink4 [3];
  pct_t  kpct4;
  frac_t kfrac4;

  always_ff @(posedge clk) begin
    if (ce) begin
      kpct4  <= kpct3;
      kfrac4 <= kfrac3;
      for (int c = 0; c < 3; c++) begin
        ink4[c] <= ink_next[c];
      end
    end
  end

  assign m_tvalid = v4;
  assign m_tdata  = {
    (OUT_DATA_W - 4 * PCT_W - FRAC_W)'(0),
    kfrac4, kpct4, ink4[2], ink4[1], ink4[0]
  };

endmodule

[design/rgbcmyk_checker.sv]
// ----------------------------------------------------------------------------
// rgbcmyk_checker
// Port-level checks for the RGB to CMYK converter, bound to the top level.
// ----------------------------------------------------------------------------
module rgbcmyk_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic [rgbcmyk_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [rgbcmyk_pkg::OUT_DATA_W-1:0] m_tdata
);
  import rgbcmyk_pkg::*;

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result transaction dropped while stalled");

  // A stalled result keeps its data.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result data changed while stalled");

  // The input side only backs up when the output is full and stalled.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled with room in the pipeline");

  // Every percentage stays within one hundred percent and padding is zero.
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[13:0] <= 14'd10000 && m_tdata[27:14] <= 14'd10000 &&
                 m_tdata[41:28] <= 14'd10000 && m_tdata[55:42] <= 14'd10000 &&
                 m_tdata[79:73] == '0)
    else $error("result field out of range");

  // Full key means a black pixel, which carries no ink.
  a_black: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[72:56] == 17'd65536 |->
      m_tdata[41:0] == '0 && m_tdata[55:42] == 14'd10000)
    else $error("black pixel result inconsistent");

endmodule

bind rgb_to_cmyk_pixel_top rgbcmyk_checker u_rgbcmyk_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[tb/rgb_to_cmyk_pixel_top_tb.sv]
// ----------------------------------------------------------------------------
// rgb_to_cmyk_pixel_top_tb
// Self-checking testbench for the pipelined RGB to CMYK pixel converter.
// Pixels are driven into the slave stream, and each output transaction is
// checked against a CMYK prediction made when the pixel was accepted.
// Both stream sides are throttled at random.
// ----------------------------------------------------------------------------
module rgb_to_cmyk_pixel_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbcmyk_pkg::*;

  // The pipeline is four stages deep. The tail wait covers that with margin.
  localparam int PIPE_TAIL   = 16;
  // The slowest correct run is roughly 2100 pixels long.
  // This limit leaves a wide margin above that.
  localparam int CYCLE_LIMIT = 400000;

  // One converted pixel, unpacked from m_tdata.
  typedef struct packed {
    pct_t  cyan;
    pct_t  magenta;
    pct_t  yellow;
    pct_t  key;
    frac_t key_fraction;
  } cmyk_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // Expected CMYK results, oldest first, one per accepted pixel.
  cmyk_t cmyk_q[$];
  int    mismatch_count = 0;
  int    cycle_count    = 0;
  // Chance, in percent, that the pixel source or the result sink idles in
  // a given cycle.
  int    src_idle_pct   = 0;
  int    sink_idle_pct  = 0;

  cmyk_t got_cmyk;
  cmyk_t want_cmyk;

  rgb_to_cmyk_pixel_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Round-to-nearest, halves up, of num * scale / den.
  function automatic int unsigned round_ratio(int unsigned num, int unsigned scale,
                                              int unsigned den);
    return (2 * num * scale + den) / (2 * den);
  endfunction

  // Predict the CMYK result for one pixel. The brightest channel sets the
  // key, and each ink is that channel's shortfall from the brightest one.
  // A black pixel has no brightest channel, so all inks are zero and the
  // key is full.
  function automatic cmyk_t predict_cmyk(chan_t red, chan_t green, chan_t blue);
    cmyk_t       res;
    int unsigned peak;
    int unsigned dark;
    peak = red;
    if (green > peak) peak = green;
    if (blue > peak) peak = blue;
    dark = CHAN_FULL - peak;
    if (peak == 0) begin
      res.cyan    = '0;
      res.magenta = '0;
      res.yellow  = '0;
    end else begin
      res.cyan    = pct_t'(round_ratio(peak - red, PCT_SCALE, peak));
      res.magenta = pct_t'(round_ratio(peak - green, PCT_SCALE, peak));
      res.yellow  = pct_t'(round_ratio(peak - blue, PCT_SCALE, peak));
    end
    res.key          = pct_t'(round_ratio(dark, PCT_SCALE, CHAN_FULL));
    res.key_fraction = frac_t'(round_ratio(dark, FRAC_SCALE, CHAN_FULL));
    return res;
  endfunction

  // The result sink. The ready is redrawn at every clock edge.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Input monitor: each accepted pixel transaction queues its prediction.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      cmyk_q.push_back(predict_cmyk(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]));
    end
  end

  // Output checker. Each result transaction is compared field by field with
  // the oldest pending prediction. The padding bits above key_fraction must
  // stay zero.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_cmyk.cyan         = m_tdata[PCT_W-1:0];
      got_cmyk.magenta      = m_tdata[2*PCT_W-1:PCT_W];
      got_cmyk.yellow       = m_tdata[3*PCT_W-1:2*PCT_W];
      got_cmyk.key          = m_tdata[4*PCT_W-1:3*PCT_W];
      got_cmyk.key_fraction = m_tdata[4*PCT_W+FRAC_W-1:4*PCT_W];
      if (cmyk_q.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("[%0t] result with no pixel pending: c=%0d m=%0d y=%0d k=%0d kf=%0d",
                   $realtime, got_cmyk.cyan, got_cmyk.magenta, got_cmyk.yellow,
                   got_cmyk.key, got_cmyk.key_fraction);
        end
        mismatch_count++;
      end else begin
        want_cmyk = cmyk_q.pop_front();
        if (got_cmyk.cyan !== want_cmyk.cyan || got_cmyk.magenta !== want_cmyk.magenta ||
            got_cmyk.yellow !== want_cmyk.yellow || got_cmyk.key !== want_cmyk.key ||
            got_cmyk.key_fraction !== want_cmyk.key_fraction ||
            m_tdata[OUT_DATA_W-1:4*PCT_W+FRAC_W] !== '0) begin
          if (mismatch_count < 10) begin
            $display("[%0t] exp c=%0d m=%0d y=%0d k=%0d kf=%0d", $realtime,
                     want_cmyk.cyan, want_cmyk.magenta, want_cmyk.yellow,
                     want_cmyk.key, want_cmyk.key_fraction);
            $display("[%0t] got c=%0d m=%0d y=%0d k=%0d kf=%0d pad=%h", $realtime,
                     got_cmyk.cyan, got_cmyk.magenta, got_cmyk.yellow,
                     got_cmyk.key, got_cmyk.key_fraction,
                     m_tdata[OUT_DATA_W-1:4*PCT_W+FRAC_W]);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog. A hung handshake ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Offer one pixel and return right after the edge that accepted it.
  // It is called just after a rising edge. Every pass through the loops
  // advances one clock, so s_tvalid gets at most one assignment per step.
  // On return, s_tvalid is still high, so a back-to-back pixel keeps it up.
  task automatic send_pixel(input chan_t red, input chan_t green, input chan_t blue);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {blue, green, red};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Lower the valid and wait until every queued prediction has been matched.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (cmyk_q.size() != 0) @(posedge clk);
  endtask

  // Corner pixels: black, white, the primaries and secondaries, tiny
  // brightest channels where the division is coarsest, and mixes whose
  // quotients land on or near a rounding boundary.
  task automatic test_corner_pixels();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd1,   8'd1,   8'd1);
    send_pixel(8'd2,   8'd1,   8'd0);
    send_pixel(8'd3,   8'd1,   8'd2);
    send_pixel(8'd7,   8'd6,   8'd5);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd254, 8'd1,   8'd127);
    send_pixel(8'd255, 8'd254, 8'd1);
    send_pixel(8'd200, 8'd100, 8'd50);
    send_pixel(8'd170, 8'd85,  8'd0);
    send_pixel(8'd85,  8'd170, 8'd254);
    send_pixel(8'd127, 8'd128, 8'd129);
  endtask

  // Random pixels. Most are uniform. The rest are grays, pixels with a dead
  // channel, very dark pixels, and channels pinned to zero or full.
  task automatic test_random_pixels(input int count, input int src_idle,
                                    input int sink_idle);
    chan_t red;
    chan_t green;
    chan_t blue;
    src_idle_pct  = src_idle;
    sink_idle_pct = sink_idle;
    repeat (count) begin
      red   = chan_t'($urandom);
      green = chan_t'($urandom);
      blue  = chan_t'($urandom);
      case ($urandom_range(0, 9))
        0: begin
          green = red;
          blue  = red;
        end
        1: begin
          case ($urandom_range(0, 2))
            0: red   = '0;
            1: green = '0;
            default: blue = '0;
          endcase
        end
        2: begin
          red   = chan_t'($urandom_range(0, 7));
          green = chan_t'($urandom_range(0, 7));
          blue  = chan_t'($urandom_range(0, 7));
        end
        3: begin
          red   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          blue  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        end
        default: ;
      endcase
      send_pixel(red, green, blue);
    end
  endtask

  // The source stops until the pipeline has emptied, holds off briefly, then
  // resumes. This checks that the pipeline restarts cleanly from empty.
  task automatic test_pause_and_resume();
    test_random_pixels(40, 10, 30);
    drain_results();
    repeat ($urandom_range(1, 8)) @(posedge clk);
    test_random_pixels(40, 10, 30);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_pixels();
    test_random_pixels(700, 15, 77);
    test_random_pixels(700, 77, 15);
    test_random_pixels(600, 0, 0);
    test_pause_and_resume();

    // Let the last results come out, then keep clocking the pipeline to reveal
    // any stray transaction.
    drain_results();
    repeat (PIPE_TAIL) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
design/rgbcmyk_pkg.sv
design/rgb_to_cmyk_pixel_top.sv
design/rgbcmyk_checker.sv
tb/rgb_to_cmyk_pixel_top_tb.sv
